>>> rtl/core/fat12_root_directory_search_assert.svh
// Assertion macros for the FAT12 root directory search block.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef FAT12_ROOT_DIRECTORY_SEARCH_ASSERT_SVH
`define FAT12_ROOT_DIRECTORY_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// Check that prop holds at every edge outside reset.
`define FRDS_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("fat12 root directory search: check failed");

// Check that post holds in the cycle after pre.
`define FRDS_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("fat12 root directory search: check failed");

`else

`define FRDS_ASSERT(name, prop)
`define FRDS_ASSERT_NEXT(name, pre, post)

`endif

`endif

>>> rtl/core/fat12rd_pkg.sv
// Shared types and constants of the FAT12 root directory search block.
// No dependencies; used by fat12rd_scan and fat12_root_directory_search.
package fat12rd_pkg;

	localparam int ENTRY_BYTES        = 32;
	localparam int ENTRIES_PER_SECTOR = 16;
	localparam int POS_W              = $clog2(ENTRY_BYTES);

	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(ENTRY_BYTES - 1);
	localparam logic [POS_W-1:0] NAME_LEN    = POS_W'(8);
	localparam logic [POS_W-1:0] NAME_END    = POS_W'(11);
	localparam logic [POS_W-1:0] CLUSTER_POS = POS_W'(26);
	localparam logic [POS_W-1:0] SIZE_POS    = POS_W'(28);

	localparam logic [7:0] DELETED_MARK = 8'hE5;
	localparam logic [7:0] END_MARK     = 8'h00;

	// Configuration register indexes
	localparam logic [2:0] CFG_RESERVED_SECTORS = 3'd0;
	localparam logic [2:0] CFG_FAT_COPIES       = 3'd1;
	localparam logic [2:0] CFG_SECTORS_PER_FAT  = 3'd2;
	localparam logic [2:0] CFG_ROOT_ENTRIES     = 3'd3;
	localparam logic [2:0] CFG_CLUSTER_SECTORS  = 3'd4;
	localparam logic [2:0] CFG_QUERY_NAME       = 3'd5;
	localparam logic [2:0] CFG_QUERY_EXT        = 3'd6;

	typedef struct packed {
		logic       start_search;
		logic [7:0] dir_byte;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [15:0] start_cluster;
		logic [31:0] file_size;
		logic [31:0] first_sector;
	} result_t;

	// Search end reported by the scanner for the byte just taken
	typedef struct packed {
		logic        hit;
		logic        found;
		logic [15:0] start_cluster;
		logic [31:0] file_size;
	} scan_evt_t;

endpackage

>>> rtl/core/fat12rd_scan.sv
// Byte scanner of the FAT12 root directory search: entry framing, name
// compare and field capture. Depends on fat12rd_pkg.
module fat12rd_scan (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  fat12rd_pkg::item_t     item,
	input  logic [15:0]            entry_limit,
	input  logic [63:0]            query_name,
	input  logic [23:0]            query_ext,
	output fat12rd_pkg::scan_evt_t evt
);

	logic [fat12rd_pkg::POS_W-1:0] pos_q, pos_d, p;
	logic [15:0] passed_q, passed_d, passed_b, passed_inc;
	logic        match_q, match_d, match_b, match_e;
	logic        del_q, del_d, del_b, del_e;
	logic        done_q, done_d;
	logic [15:0] clu_q, clu_d, clu_b, clu_e;
	logic [31:0] size_q, size_d, size_b, size_e;
	logic [7:0]  b, want;

	always_comb begin
		b = item.dir_byte;
		if (item.start_search) begin
			p        = '0;
			passed_b = '0;
			match_b  = 1'b1;
			del_b    = 1'b0;
			clu_b    = '0;
			size_b   = '0;
		end else begin
			p        = pos_q;
			passed_b = passed_q;
			match_b  = match_q;
			del_b    = del_q;
			clu_b    = clu_q;
			size_b   = size_q;
		end

		case (p[2:0])
			3'd0: want = query_name[7:0];
			3'd1: want = query_name[15:8];
			3'd2: want = query_name[23:16];
			3'd3: want = query_name[31:24];
			3'd4: want = query_name[39:32];
			3'd5: want = query_name[47:40];
			3'd6: want = query_name[55:48];
			3'd7: want = query_name[63:56];
			default: want = query_name[7:0];
		endcase
		if (p >= fat12rd_pkg::NAME_LEN) begin
			case (p[1:0])
				2'd0: want = query_ext[7:0];
				2'd1: want = query_ext[15:8];
				2'd2: want = query_ext[23:16];
				default: want = query_ext[7:0];
			endcase
		end

		del_e   = del_b | ((p == '0) && (b == fat12rd_pkg::DELETED_MARK));
		match_e = match_b;
		if ((p < fat12rd_pkg::NAME_END) && (b != want))
			match_e = 1'b0;

		clu_e = clu_b;
		if ((p == fat12rd_pkg::CLUSTER_POS) || (p == fat12rd_pkg::CLUSTER_POS + 1'b1)) begin
			if (p[0])
				clu_e[15:8] = clu_b[15:8] | b;
			else
				clu_e[7:0] = clu_b[7:0] | b;
		end

		size_e = size_b;
		if (p >= fat12rd_pkg::SIZE_POS) begin
			case (p[1:0])
				2'd0: size_e[7:0]   = size_b[7:0] | b;
				2'd1: size_e[15:8]  = size_b[15:8] | b;
				2'd2: size_e[23:16] = size_b[23:16] | b;
				2'd3: size_e[31:24] = size_b[31:24] | b;
				default: size_e = size_b;
			endcase
		end

		passed_inc = passed_b + 16'd1;
	end

	always_comb begin
		pos_d    = pos_q;
		passed_d = passed_q;
		match_d  = match_q;
		del_d    = del_q;
		clu_d    = clu_q;
		size_d   = size_q;
		done_d   = done_q;
		evt      = '0;
		if (take) begin
			if (item.start_search) begin
				pos_d    = '0;
				passed_d = '0;
				match_d  = 1'b1;
				del_d    = 1'b0;
				clu_d    = '0;
				size_d   = '0;
				done_d   = 1'b0;
			end
			if (item.start_search && (entry_limit == '0)) begin
				done_d  = 1'b1;
				evt.hit = 1'b1;
			end else if (item.start_search || !done_q) begin
				if ((p == '0) && (b == fat12rd_pkg::END_MARK)) begin
					done_d  = 1'b1;
					evt.hit = 1'b1;
				end else if (p == fat12rd_pkg::POS_LAST) begin
					if (!del_e && match_e) begin
						done_d            = 1'b1;
						evt.hit           = 1'b1;
						evt.found         = 1'b1;
						evt.start_cluster = clu_e;
						evt.file_size     = size_e;
					end else begin
						// advance to the next entry
						passed_d = passed_inc;
						pos_d    = '0;
						match_d  = 1'b1;
						del_d    = 1'b0;
						clu_d    = '0;
						size_d   = '0;
						if (passed_inc >= entry_limit) begin
							done_d  = 1'b1;
							evt.hit = 1'b1;
						end
					end
				end else begin
					pos_d   = p + 1'b1;
					match_d = match_e;
					del_d   = del_e;
					clu_d   = clu_e;
					size_d  = size_e;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			passed_q <= '0;
			match_q  <= 1'b1;
			del_q    <= 1'b0;
			done_q   <= 1'b1;
			clu_q    <= '0;
			size_q   <= '0;
		end else begin
			pos_q    <= pos_d;
			passed_q <= passed_d;
			match_q  <= match_d;
			del_q    <= del_d;
			done_q   <= done_d;
			clu_q    <= clu_d;
			size_q   <= size_d;
		end
	end

endmodule

>>> rtl/core/fat12_root_directory_search.sv
// FAT12 root directory search.
//
// item channel: one byte of the root directory region per transfer
// (item_valid, item_stall, item). start_search set on a byte restarts the
// search with that byte as byte 0 of entry 0. Bytes are taken one per cycle
// while item_stall is low. res channel: one result per search when it ends
// (match, end marker, or floor(root_entries/16)*16 entries passed); none
// while idle. The result passes the scan event register, the sector
// multiply register and the output register before it is valid. The
// cluster offset multiply sets that depth.
// cfg channel: register writes (cfg_index, cfg_data); cfg_ready is always
// high. Write only while no search result is outstanding.
// Reset: registers take their defaults (1, 2, 9, 224, 1, spaces) and the
// block waits for start_search. While res_stall holds, the result stays and
// the pipeline keeps taking bytes until its two inner stages fill; then
// item_stall rises.
// Depends on fat12rd_pkg and fat12rd_scan.
`include "fat12_root_directory_search_assert.svh"

module fat12_root_directory_search (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  fat12rd_pkg::item_t   item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output fat12rd_pkg::result_t res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data
);

	logic [15:0] reserved_q, spf_q, root_entries_q;
	logic [7:0]  fat_copies_q, cluster_sectors_q;
	logic [63:0] query_name_q;
	logic [23:0] query_ext_q;
	logic [23:0] fat_span;
	logic [31:0] base_q;
	logic [15:0] entry_limit;
	logic        take;

	fat12rd_pkg::scan_evt_t evt, evt_s1, evt_s2;
	logic        valid_s1, valid_s2, res_v_q;
	logic [31:0] clu_off, term, term_s2;
	logic        res_free, s2_free, s1_free;
	fat12rd_pkg::result_t res_q;
	logic        res_zero;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q        <= 16'd1;
			fat_copies_q      <= 8'd2;
			spf_q             <= 16'd9;
			root_entries_q    <= 16'd224;
			cluster_sectors_q <= 8'd1;
			query_name_q      <= {8{8'h20}};
			query_ext_q       <= {3{8'h20}};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fat12rd_pkg::CFG_RESERVED_SECTORS: reserved_q        <= cfg_data[15:0];
				fat12rd_pkg::CFG_FAT_COPIES:       fat_copies_q      <= cfg_data[7:0];
				fat12rd_pkg::CFG_SECTORS_PER_FAT:  spf_q             <= cfg_data[15:0];
				fat12rd_pkg::CFG_ROOT_ENTRIES:     root_entries_q    <= cfg_data[15:0];
				fat12rd_pkg::CFG_CLUSTER_SECTORS:  cluster_sectors_q <= cfg_data[7:0];
				fat12rd_pkg::CFG_QUERY_NAME:       query_name_q      <= cfg_data;
				fat12rd_pkg::CFG_QUERY_EXT:        query_ext_q       <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Root directory start plus its length in sectors (entries * 32 / 512)
	assign fat_span = {16'd0, fat_copies_q} * {8'd0, spf_q};

	always_ff @(posedge clk) begin
		base_q <= {16'd0, reserved_q} + {8'd0, fat_span} + {20'd0, root_entries_q[15:4]};
	end

	assign entry_limit = {root_entries_q[15:4], 4'd0};

	assign res_free   = !res_v_q || !res_stall;
	assign s2_free    = !valid_s2 || res_free;
	assign s1_free    = !valid_s1 || s2_free;
	assign item_stall = !s1_free;
	assign take       = item_valid && !item_stall;

	fat12rd_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.item        (item),
		.entry_limit (entry_limit),
		.query_name  (query_name_q),
		.query_ext   (query_ext_q),
		.evt         (evt)
	);

	// Cluster offset wraps modulo 2^32 for clusters below 2
	assign clu_off = {16'd0, evt_s1.start_cluster} - 32'd2;
	assign term    = clu_off * {24'd0, cluster_sectors_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= evt.hit;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (res_free)
				res_v_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free)
			evt_s1 <= evt;
		if (s2_free) begin
			evt_s2  <= evt_s1;
			term_s2 <= term;
		end
		if (res_free) begin
			res_q.found         <= evt_s2.found;
			res_q.start_cluster <= evt_s2.start_cluster;
			res_q.file_size     <= evt_s2.file_size;
			res_q.first_sector  <= evt_s2.found ? (base_q + term_s2) : 32'd0;
		end
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

	assign res_zero = (res.start_cluster == 16'd0) && (res.file_size == 32'd0)
		&& (res.first_sector == 32'd0);

	`FRDS_ASSERT(a_stall_needs_full_s1, !item_stall || valid_s1)
	`FRDS_ASSERT(a_miss_is_zero, !res_valid || res.found || res_zero)
	`FRDS_ASSERT_NEXT(a_s2_holds_when_blocked, valid_s2 && res_v_q && res_stall, valid_s2)

endmodule

>>> dv/tb.sv
// Testbench for fat12_root_directory_search: streams root directory bytes and
// checks each search result against a cycle-free predictor kept in this file.
// Depends on fat12rd_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SECTOR_BYTES = 512;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	fat12rd_pkg::item_t   item       = '0;
	logic                 res_valid;
	logic                 res_stall  = 1'b0;
	fat12rd_pkg::result_t res;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [2:0]           cfg_index  = fat12rd_pkg::CFG_RESERVED_SECTORS;
	logic [63:0]          cfg_data   = '0;

	// Register shadow, reset values of the block
	logic [15:0] reg_reserved        = 16'd1;
	logic [7:0]  reg_fat_copies      = 8'd2;
	logic [15:0] reg_sectors_per_fat = 16'd9;
	logic [15:0] reg_root_entries    = 16'd224;
	logic [7:0]  reg_cluster_sectors = 8'd1;
	logic [63:0] q_name              = {8{8'h20}};
	logic [23:0] q_ext               = {3{8'h20}};

	// Search state
	logic [4:0]  byte_pos       = '0;
	logic [15:0] entries_passed = '0;
	logic        name_ok        = 1'b1;
	logic        entry_deleted  = 1'b0;
	logic [15:0] clus_cap       = '0;
	logic [31:0] size_cap       = '0;
	logic        search_done    = 1'b1;

	fat12rd_pkg::result_t pending_results[$];
	int      mismatch_count = 0;
	int      items_counted  = 0;
	int      search_results = 0;
	int      cycle_count    = 0;
	int      item_idle_pct  = 0;
	int      res_stall_pct  = 0;
	int      hold_left      = 0;
	int      idle_table[4]  = '{0, 59, 0, 33};
	int      stall_table[4] = '{0, 0, 59, 33};

	fat12_root_directory_search i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [15:0] entry_limit();
		// whole sectors of 16 entries only
		return {reg_root_entries[15:4], 4'd0};
	endfunction

	task automatic clear_entry();
		byte_pos      = '0;
		name_ok       = 1'b1;
		entry_deleted = 1'b0;
		clus_cap      = '0;
		size_cap      = '0;
	endtask

	task automatic close_search(input logic hit);
		fat12rd_pkg::result_t r;
		logic [31:0] root_start;
		logic [31:0] root_secs;
		r = '0;
		if (hit) begin
			root_start = 32'(reg_reserved) + 32'(reg_fat_copies) * 32'(reg_sectors_per_fat);
			root_secs  = (32'(reg_root_entries) * 32'(fat12rd_pkg::ENTRY_BYTES))
				/ 32'(SECTOR_BYTES);
			r.found         = 1'b1;
			r.start_cluster = clus_cap;
			r.file_size     = size_cap;
			// clusters below 2 wrap modulo 2^32
			r.first_sector  = root_start + root_secs
				+ (32'(clus_cap) - 32'd2) * 32'(reg_cluster_sectors);
		end
		pending_results.push_back(r);
		search_results++;
		search_done = 1'b1;
	endtask

	task automatic scan_dir_byte(input fat12rd_pkg::item_t it, output bit taken);
		logic [4:0] pos;
		taken = 1'b0;
		if (it.start_search) begin
			clear_entry();
			entries_passed = '0;
			search_done    = 1'b0;
			if (entry_limit() == 16'd0) begin
				taken = 1'b1;
				close_search(1'b0);
				return;
			end
		end
		if (search_done)
			return;
		taken = 1'b1;
		pos   = byte_pos;
		if (pos == 5'd0) begin
			if (it.dir_byte == fat12rd_pkg::END_MARK) begin
				close_search(1'b0);
				return;
			end
			if (it.dir_byte == fat12rd_pkg::DELETED_MARK)
				entry_deleted = 1'b1;
		end
		if (pos < fat12rd_pkg::NAME_LEN) begin
			if (it.dir_byte != q_name[8*pos +: 8])
				name_ok = 1'b0;
		end else if (pos < fat12rd_pkg::NAME_END) begin
			if (it.dir_byte != q_ext[8*(pos-fat12rd_pkg::NAME_LEN) +: 8])
				name_ok = 1'b0;
		end else if (pos == fat12rd_pkg::CLUSTER_POS || pos == fat12rd_pkg::CLUSTER_POS + 1) begin
			clus_cap[8*(pos-fat12rd_pkg::CLUSTER_POS) +: 8] = it.dir_byte;
		end else if (pos >= fat12rd_pkg::SIZE_POS) begin
			size_cap[8*(pos-fat12rd_pkg::SIZE_POS) +: 8] = it.dir_byte;
		end
		if (pos == fat12rd_pkg::POS_LAST) begin
			if (!entry_deleted && name_ok) begin
				close_search(1'b1);
			end else begin
				entries_passed = entries_passed + 16'd1;
				clear_entry();
				if (entries_passed >= entry_limit())
					close_search(1'b0);
			end
		end else begin
			byte_pos = pos + 5'd1;
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < 50)
			$display("%0t: %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : result_check
		fat12rd_pkg::result_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no search end pending", 32'(res.found), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (res.found !== want.found)
					report_mismatch("found", 32'(res.found), 32'(want.found));
				if (res.start_cluster !== want.start_cluster)
					report_mismatch("start_cluster", 32'(res.start_cluster),
						32'(want.start_cluster));
				if (res.file_size !== want.file_size)
					report_mismatch("file_size", res.file_size, want.file_size);
				if (res.first_sector !== want.first_sector)
					report_mismatch("first_sector", res.first_sector, want.first_sector);
			end
		end
	end

	// Receiver: random stall, or a long hold-off counted down here
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(99) < res_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic send_byte(input logic start, input logic [7:0] b);
		fat12rd_pkg::item_t it;
		bit    taken;
		it.start_search = start;
		it.dir_byte     = b;
		while ($urandom_range(99) < item_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall !== 1'b0);
		scan_dir_byte(it, taken);
		if (taken)
			items_counted++;
	endtask

	// Send the first nbytes of one 32-byte directory entry
	task automatic send_entry(input logic restart, input logic [63:0] nm,
			input logic [23:0] ex, input logic [15:0] clus, input logic [31:0] fsize,
			input int nbytes);
		logic [7:0] b;
		for (int i = 0; i < nbytes; i++) begin
			if (i < fat12rd_pkg::NAME_LEN)
				b = nm[8*i +: 8];
			else if (i < fat12rd_pkg::NAME_END)
				b = ex[8*(i-fat12rd_pkg::NAME_LEN) +: 8];
			else if (i == fat12rd_pkg::CLUSTER_POS || i == fat12rd_pkg::CLUSTER_POS + 1)
				b = clus[8*(i-fat12rd_pkg::CLUSTER_POS) +: 8];
			else if (i >= fat12rd_pkg::SIZE_POS)
				b = fsize[8*(i-fat12rd_pkg::SIZE_POS) +: 8];
			else
				b = 8'($urandom);
			send_byte(restart && i == 0, b);
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// bytes that end no search may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			fat12rd_pkg::CFG_RESERVED_SECTORS: reg_reserved        = data[15:0];
			fat12rd_pkg::CFG_FAT_COPIES:       reg_fat_copies      = data[7:0];
			fat12rd_pkg::CFG_SECTORS_PER_FAT:  reg_sectors_per_fat = data[15:0];
			fat12rd_pkg::CFG_ROOT_ENTRIES:     reg_root_entries    = data[15:0];
			fat12rd_pkg::CFG_CLUSTER_SECTORS:  reg_cluster_sectors = data[7:0];
			fat12rd_pkg::CFG_QUERY_NAME:       q_name              = data;
			fat12rd_pkg::CFG_QUERY_EXT:        q_ext               = data[23:0];
			default: ;
		endcase
	endtask

	// Write every register; unused upper data bits carry junk
	task automatic write_all(input logic [15:0] rsv, input logic [7:0] fats,
			input logic [15:0] spf, input logic [15:0] roots, input logic [7:0] spc,
			input logic [63:0] nm, input logic [23:0] ex);
		write_reg(fat12rd_pkg::CFG_RESERVED_SECTORS, {32'($urandom), 16'($urandom), rsv});
		write_reg(fat12rd_pkg::CFG_FAT_COPIES,       {32'($urandom), 24'($urandom), fats});
		write_reg(fat12rd_pkg::CFG_SECTORS_PER_FAT,  {32'($urandom), 16'($urandom), spf});
		write_reg(fat12rd_pkg::CFG_ROOT_ENTRIES,     {32'($urandom), 16'($urandom), roots});
		write_reg(fat12rd_pkg::CFG_CLUSTER_SECTORS,  {32'($urandom), 24'($urandom), spc});
		write_reg(fat12rd_pkg::CFG_QUERY_NAME,       nm);
		write_reg(fat12rd_pkg::CFG_QUERY_EXT,        {32'($urandom), 8'($urandom), ex});
	endtask

	// Space padded text, first character in the low byte
	function automatic logic [63:0] text_bytes(input string s);
		logic [63:0] v;
		v = {8{8'h20}};
		for (int i = 0; i < s.len() && i < 8; i++)
			v[8*i +: 8] = s[i];
		return v;
	endfunction

	function automatic logic [63:0] random_text(input int maxlen);
		logic [63:0] v;
		int          n;
		v = {8{8'h20}};
		n = $urandom_range(0, maxlen);
		for (int i = 0; i < n; i++)
			v[8*i +: 8] = 8'($urandom_range(8'h41, 8'h5A));
		return v;
	endfunction

	// One search: well-formed entries, some near misses, deleted entries,
	// junk, cut-short entries and end markers
	task automatic random_search();
		bit          first;
		int          n_ent;
		int          pick;
		int          cut;
		int          k;
		logic [63:0] nm;
		logic [23:0] ex;
		logic [15:0] clus;
		first = 1'b1;
		n_ent = $urandom_range(1, 3);
		for (int e = 0; e < n_ent; e++) begin
			if (!first && search_done)
				break;
			pick = $urandom_range(99);
			nm   = q_name;
			ex   = q_ext;
			clus = 16'($urandom);
			cut  = fat12rd_pkg::ENTRY_BYTES;
			if (pick >= 90) begin
				send_byte(first, fat12rd_pkg::END_MARK);
				break;
			end
			if (pick >= 60) begin
				nm = {$urandom, $urandom};
				ex = 24'($urandom);
			end else if (pick >= 45) begin
				nm[7:0] = fat12rd_pkg::DELETED_MARK;
			end else if (pick >= 25) begin
				k = $urandom_range(0, 10);
				if (k < 8)
					nm[8*k +: 8] = 8'($urandom);
				else
					ex[8*(k-8) +: 8] = 8'($urandom);
			end
			case ($urandom_range(9))
				0: clus = 16'd0;
				1: clus = 16'd1;
				2: clus = 16'hFFFF;
				default: ;
			endcase
			if ($urandom_range(99) < 6)
				cut = $urandom_range(1, fat12rd_pkg::ENTRY_BYTES - 1);
			send_entry(first, nm, ex, clus, $urandom, cut);
			first = 1'b0;
			if (cut < fat12rd_pkg::ENTRY_BYTES)
				break;
		end
		// stray bytes after the search ended are dropped by the block
		if (search_done && $urandom_range(99) < 15)
			repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom));
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed_search();
		logic [63:0] holed;
		holed = text_bytes("KERNEL");
		holed[31:24] = fat12rd_pkg::END_MARK;
		send_byte(1'b0, 8'hA5);
		send_byte(1'b1, fat12rd_pkg::END_MARK);
		// restart in the middle of an entry
		send_entry(1'b1, q_name, q_ext, 16'h0000, 32'd0, 12);
		send_entry(1'b1, {q_name[63:8], fat12rd_pkg::DELETED_MARK}, q_ext, 16'h1234, 32'd77,
			fat12rd_pkg::ENTRY_BYTES);
		send_entry(1'b0, holed, q_ext, 16'h0033, 32'd5, fat12rd_pkg::ENTRY_BYTES);
		send_entry(1'b0, q_name, q_ext, 16'h0001, 32'h8000_0000, fat12rd_pkg::ENTRY_BYTES);
		send_byte(1'b0, fat12rd_pkg::END_MARK);
	endtask

	task automatic test_register_extremes();
		item_idle_pct = 33;
		res_stall_pct = 33;
		// query starts with the deleted mark: a name match is still skipped
		wait_drained();
		write_all(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF,
			{{7{8'h20}}, fat12rd_pkg::DELETED_MARK}, {3{8'h20}});
		send_entry(1'b1, q_name, q_ext, 16'h0BAD, 32'd5, fat12rd_pkg::ENTRY_BYTES);
		send_byte(1'b0, fat12rd_pkg::END_MARK);
		// fewer than 16 entries: the start byte alone ends the search
		wait_drained();
		write_reg(fat12rd_pkg::CFG_ROOT_ENTRIES, {48'($urandom), 16'd15});
		send_byte(1'b1, 8'h41);
		send_byte(1'b0, 8'h42);
		wait_drained();
		write_reg(fat12rd_pkg::CFG_ROOT_ENTRIES, {48'($urandom), 16'd0});
		send_byte(1'b1, fat12rd_pkg::END_MARK);
		// an all-zero query meets the end marker first
		wait_drained();
		write_all(16'd1, 8'd2, 16'd9, 16'd224, 8'd1, 64'd0, 24'd0);
		send_entry(1'b1, 64'd0, 24'd0, 16'd3, 32'd3, 4);
	endtask

	task automatic test_entry_limit();
		logic [63:0] nm;
		wait_drained();
		write_all(16'd0, 8'd0, 16'd0, 16'd16, 8'd1, text_bytes("README"),
			24'(text_bytes("TXT")));
		item_idle_pct = idle_table[0];
		res_stall_pct = stall_table[0];
		// a dot is an ordinary byte
		send_entry(1'b1, text_bytes("README.T"), 24'(text_bytes("XT")), 16'd5, 32'd100,
			fat12rd_pkg::ENTRY_BYTES);
		// run out of entries: 16 misses end the search
		for (int e = 1; e < 16; e++) begin
			item_idle_pct = idle_table[e / 4];
			res_stall_pct = stall_table[e / 4];
			nm = {$urandom, $urandom};
			nm[7:0] = 8'h5A;
			send_entry(1'b0, nm, 24'($urandom), 16'($urandom), $urandom,
				fat12rd_pkg::ENTRY_BYTES);
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		write_all(16'd1, 8'd2, 16'd9, 16'd224, 8'd1, text_bytes("BOOT"),
			24'(text_bytes("BIN")));
		item_idle_pct = 0;
		res_stall_pct = 0;
		// long hold-off while searches keep ending: the input must stall
		hold_left = 100;
		repeat (12) send_byte(1'b1, fat12rd_pkg::END_MARK);
		send_entry(1'b1, q_name, q_ext, 16'($urandom), $urandom, fat12rd_pkg::ENTRY_BYTES);
		// pause until every result is out, then carry on without a write
		wait_drained();
		send_entry(1'b1, q_name, q_ext, 16'($urandom), $urandom, fat12rd_pkg::ENTRY_BYTES);
		repeat (2) send_byte(1'b1, fat12rd_pkg::END_MARK);
	endtask

	task automatic test_random_searches();
		int          goal;
		int          pick;
		logic [15:0] roots;
		logic [63:0] nm;
		logic [23:0] ex;
		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			nm = ($urandom_range(99) < 60) ? random_text(8) : {$urandom, $urandom};
			ex = ($urandom_range(99) < 60) ? 24'(random_text(3)) : 24'($urandom);
			case (ph)
				0: write_all(16'd0, 8'd0, 16'd0, 16'd16, 8'd1, nm, ex);
				3: write_all(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, nm, ex);
				default: begin
					pick  = $urandom_range(99);
					roots = (pick < 15) ? 16'($urandom_range(0, 15))
						: (pick < 30) ? 16'd224 : 16'($urandom_range(16, 47));
					write_all(16'($urandom), 8'($urandom), 16'($urandom), roots,
						8'($urandom_range(1, 255)), nm, ex);
				end
			endcase
			item_idle_pct = idle_table[ph];
			res_stall_pct = stall_table[ph];
			goal = items_counted + 12;
			while (items_counted < goal)
				random_search();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_search();
		test_register_extremes();
		test_entry_limit();
		test_backpressure();
		test_random_searches();
		wait_drained();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> fat12_root_directory_search.f
+incdir+rtl/core
rtl/core/fat12rd_pkg.sv
rtl/core/fat12rd_scan.sv
rtl/core/fat12_root_directory_search.sv
dv/tb.sv
